// ===== hw/rtl/ara_pkg.sv =====
// ============================================================================
// ara_pkg - shared constants and types for the roll angle pipeline
// Fixed-point formats, arctangent table and special-case codes.
// ============================================================================
`default_nettype none

package ara_pkg;

    // Result format and iteration count
    localparam int FRAC_BITS     = 8;
    localparam int CORDIC_STAGES = 16;

    // Sample and result widths
    localparam int SAMPLE_W = 16;
    localparam int ROLL_W   = 15;

    // Operand pre-scale and internal widths
    localparam int PRESCALE = 8;
    localparam int XY_W     = 27;     // |v| * 2^8 grows by gain * sqrt(2) < 2^25
    localparam int ACC_FRAC = 20;
    localparam int ACC_W    = 29;     // degrees, 20 fraction bits, signed
    localparam int TABLE_LEN = 24;

    // Output rounding
    localparam int RND_SHIFT = ACC_FRAC - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(64'sd1 <<< (RND_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] ANG_LIMIT = ACC_W'(64'sd90 <<< ACC_FRAC);
    localparam logic signed [ACC_W-1:0] FULL_SCALE = ACC_W'(64'sd90 <<< FRAC_BITS);

    // atan(2^-i) in degrees, 20 fraction bits
    localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
        29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
        29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
        29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
        29'sd917,      29'sd458,      29'sd229,      29'sd115,
        29'sd57,       29'sd29,       29'sd14,       29'sd7
    };

    // Input classification, carried down the pipeline with the operands
    typedef enum logic [1:0] {
        CASE_NORMAL,
        CASE_Y_ZERO,
        CASE_Z_ZERO,
        CASE_BOTH_ZERO
    } case_t;

endpackage : ara_pkg

`default_nettype wire

// ===== hw/rtl/accel_roll_angle.sv =====
// ============================================================================
// accel_roll_angle - folded roll angle from one Y/Z accelerometer sample
// Vectoring CORDIC arctangent, one register stage per iteration.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one signed Y/Z sample pair per
//   transfer. Output channel (out_valid/out_ready) returns roll_angle, equal
//   to 90 - atan(|z|/|y|) degrees with FRAC_BITS fraction bits, and
//   angle_valid, which is low only when both axes read zero.
//   The sample passes through registered stages: one stage takes
//   magnitudes and classifies the sample, one stage per CORDIC iteration,
//   one stage clamps, rounds and folds the angle into the output register.
//   Throughput is one sample per cycle unless the output stalls; each iteration has its own adders,
//   so nothing is shared between samples.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready drops; no item is lost or repeated. Holes
//   in the pipeline keep moving while the output register is empty.
//   Reset clears all stage valid bits; the payload registers are not reset.
// ============================================================================
`default_nettype none

module accel_roll_angle (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [ara_pkg::SAMPLE_W-1:0]   accel_y,
    input  wire logic signed [ara_pkg::SAMPLE_W-1:0]   accel_z,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic             [ara_pkg::ROLL_W-1:0]     roll_angle,
    output logic                                       angle_valid
);

    localparam int N  = ara_pkg::CORDIC_STAGES;
    localparam int XW = ara_pkg::XY_W;
    localparam int AW = ara_pkg::ACC_W;
    localparam int SW = ara_pkg::SAMPLE_W;

    // Stage 0 holds the pre-scaled magnitudes, stage i+1 the result of iteration i
    logic signed [XW-1:0]   x_reg    [0:N];
    logic signed [XW-1:0]   x_next   [0:N];
    logic signed [XW-1:0]   y_reg    [0:N];
    logic signed [XW-1:0]   y_next   [0:N];
    logic signed [AW-1:0]   ang_reg  [0:N];
    logic signed [AW-1:0]   ang_next [0:N];
    ara_pkg::case_t         case_reg [0:N];
    ara_pkg::case_t         case_next[0:N];
    logic [N:0]             valid_reg;

    logic                   out_valid_reg;
    logic [ara_pkg::ROLL_W-1:0] roll_angle_reg;
    logic [ara_pkg::ROLL_W-1:0] roll_angle_next;
    logic                   angle_valid_reg;
    logic                   angle_valid_next;

    logic                   advance;
    logic [SW-1:0]          mag_y;
    logic [SW-1:0]          mag_z;
    logic signed [AW-1:0]   ang_clamp;
    logic signed [AW-1:0]   ang_rnd;
    logic signed [AW-1:0]   fold;

    // Whole pipeline moves when the output register is free or being drained
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign roll_angle  = roll_angle_reg;
    assign angle_valid = angle_valid_reg;

    always_comb
    begin
        // Entry stage: magnitudes (-32768 maps to 32768 in 16 unsigned bits)
        mag_y = accel_y[SW-1] ? SW'(-accel_y) : SW'(accel_y);
        mag_z = accel_z[SW-1] ? SW'(-accel_z) : SW'(accel_z);

        x_next[0]   = signed'({{(XW - SW - ara_pkg::PRESCALE){1'b0}}, mag_y,
                               {ara_pkg::PRESCALE{1'b0}}});
        y_next[0]   = signed'({{(XW - SW - ara_pkg::PRESCALE){1'b0}}, mag_z,
                               {ara_pkg::PRESCALE{1'b0}}});
        ang_next[0] = '0;

        if (mag_y == '0 && mag_z == '0)
            case_next[0] = ara_pkg::CASE_BOTH_ZERO;
        else if (mag_y == '0)
            case_next[0] = ara_pkg::CASE_Y_ZERO;
        else if (mag_z == '0)
            case_next[0] = ara_pkg::CASE_Z_ZERO;
        else
            case_next[0] = ara_pkg::CASE_NORMAL;

        // One vectoring iteration per stage; shifts floor toward minus infinity
        for (int i = 0; i < N; i++)
        begin
            if (!y_reg[i][XW-1])
            begin
                x_next[i+1]   = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1]   = y_reg[i] - (x_reg[i] >>> i);
                ang_next[i+1] = ang_reg[i] + ara_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_next[i+1]   = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1]   = y_reg[i] + (x_reg[i] >>> i);
                ang_next[i+1] = ang_reg[i] - ara_pkg::ATAN_TAB[i];
            end
            case_next[i+1] = case_reg[i];
        end
    end

    // Final stage: clamp to 0..90, round to FRAC_BITS, fold at 90
    always_comb
    begin
        if (ang_reg[N][AW-1])
            ang_clamp = '0;
        else if (ang_reg[N] > ara_pkg::ANG_LIMIT)
            ang_clamp = ara_pkg::ANG_LIMIT;
        else
            ang_clamp = ang_reg[N];

        ang_rnd = (ang_clamp + ara_pkg::RND_HALF) >>> ara_pkg::RND_SHIFT;
        fold    = ara_pkg::FULL_SCALE - ang_rnd;
        if (fold[AW-1])
            fold = '0;

        angle_valid_next = 1'b1;
        case (case_reg[N])
            ara_pkg::CASE_NORMAL:
            begin
                roll_angle_next = fold[ara_pkg::ROLL_W-1:0];
            end
            ara_pkg::CASE_Y_ZERO:
            begin
                roll_angle_next = '0;
            end
            ara_pkg::CASE_Z_ZERO:
            begin
                roll_angle_next = ara_pkg::FULL_SCALE[ara_pkg::ROLL_W-1:0];
            end
            default:
            begin
                roll_angle_next  = '0;
                angle_valid_next = 1'b0;
            end
        endcase
    end

    // Control: valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[N-1:0], in_valid};
            out_valid_reg <= valid_reg[N];
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i <= N; i++)
            begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                ang_reg[i]  <= ang_next[i];
                case_reg[i] <= case_next[i];
            end
            roll_angle_reg  <= roll_angle_next;
            angle_valid_reg <= angle_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // A stall must freeze every stage's valid bit
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg) && $stable(out_valid_reg))
        else $error("pipeline valid bits moved during a stall");

    // A result flagged invalid always carries a zero angle
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !angle_valid |-> roll_angle == '0)
        else $error("invalid result with nonzero angle");

    // X is positive at the last iteration stage for a regular sample
    a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N] && case_reg[N] == ara_pkg::CASE_NORMAL
            |-> !x_reg[N][XW-1] && x_reg[N] != '0)
        else $error("CORDIC x operand overflowed");
`endif

endmodule : accel_roll_angle

`default_nettype wire
